// File: hw/rtl/b64d_pkg.sv
// Shared types, constants and the character lookup for the base64 stream decoder.
package b64d_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int ACC_W           = 18;
    localparam int SEXTET_W        = 6;

    // Byte counts carried by a queued job.
    localparam logic [1:0] NB_NONE  = 2'd0;
    localparam logic [1:0] NB_ONE   = 2'd1;
    localparam logic [1:0] NB_TWO   = 2'd2;
    localparam logic [1:0] NB_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] char_in;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       has_byte;
        logic       end_of_output;
    } out_item_t;

    // One accepted character's worth of output, handed from front to back.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            end_mark;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic                ok;
        logic [SEXTET_W-1:0] val;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t r;
        r.ok  = 1'b1;
        r.val = '0;
        if (ch inside {[8'h41:8'h5A]}) begin
            r.val = SEXTET_W'(ch - 8'h41);
        end else if (ch inside {[8'h61:8'h7A]}) begin
            r.val = SEXTET_W'(ch - 8'h61 + 8'd26);
        end else if (ch inside {[8'h30:8'h39]}) begin
            r.val = SEXTET_W'(ch - 8'h30 + 8'd52);
        end else if (ch == 8'h2B) begin
            r.val = 6'd62;
        end else if (ch == 8'h2F) begin
            r.val = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/b64d_front.sv
// Front end: accepts characters, collects sextets and builds output jobs.
module b64d_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64d_pkg::in_item_t  s_data,
    input  b64d_pkg::q_status_t q_status,
    output logic                push,
    output b64d_pkg::job_t      push_job
);
    import b64d_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next, acc_upd;
    logic [1:0]       cnt_reg, cnt_next, cnt_upd;
    logic             stop_reg, stop_next, stop_upd;
    logic             grp_done;
    logic             accept;
    logic [23:0]      word;
    sextet_t          lookup;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign lookup  = sextet_of(s_data.char_in);
    assign word    = {acc_reg, lookup.val};

    always_comb begin
        acc_upd  = acc_reg;
        cnt_upd  = cnt_reg;
        stop_upd = stop_reg;
        grp_done = 1'b0;
        if (!stop_reg) begin
            if (!lookup.ok) begin
                stop_upd = 1'b1;
            end else if (cnt_reg == 2'd3) begin
                grp_done = 1'b1;
                acc_upd  = '0;
                cnt_upd  = 2'd0;
            end else begin
                acc_upd = {acc_reg[ACC_W-SEXTET_W-1:0], lookup.val};
                cnt_upd = cnt_reg + 2'd1;
            end
        end

        push_job          = '0;
        push_job.end_mark = s_data.string_end;
        if (grp_done) begin
            push_job.bytes[0] = word[23:16];
            push_job.bytes[1] = word[15:8];
            push_job.bytes[2] = word[7:0];
            push_job.nbytes   = NB_THREE;
        end else if (s_data.string_end) begin
            // A partial group of n sextets flushes n-1 bytes.
            case (cnt_upd)
                2'd2: begin
                    push_job.bytes[0] = acc_upd[11:4];
                    push_job.nbytes   = NB_ONE;
                end
                2'd3: begin
                    push_job.bytes[0] = acc_upd[17:10];
                    push_job.bytes[1] = acc_upd[9:2];
                    push_job.nbytes   = NB_TWO;
                end
                default: push_job.nbytes = NB_NONE;
            endcase
        end

        if (s_data.string_end) begin
            acc_next  = '0;
            cnt_next  = 2'd0;
            stop_next = 1'b0;
        end else begin
            acc_next  = acc_upd;
            cnt_next  = cnt_upd;
            stop_next = stop_upd;
        end
    end

    assign push = accept && (grp_done || s_data.string_end);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            cnt_reg  <= 2'd0;
            stop_reg <= 1'b0;
        end else if (accept) begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            stop_reg <= stop_next;
        end
    end

endmodule

// File: hw/rtl/b64d_queue.sv
// Job queue between the front end and the output serializer.
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  b64d_pkg::job_t      wr_data,
    input  logic                rd_en,
    output b64d_pkg::job_t      rd_data,
    output b64d_pkg::q_status_t status
);
    import b64d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign status.full  = (cnt_reg == FULL_CNT);
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = entry_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr) begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/b64d_back.sv
// Back end: walks the head job and hands out one result per request.
module b64d_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  b64d_pkg::job_t      head_job,
    input  b64d_pkg::q_status_t q_status,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output b64d_pkg::out_item_t m_data
);
    import b64d_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic [1:0] last_idx;
    logic       is_last;
    logic [7:0] cur_byte;

    assign m_valid  = !q_status.empty;
    assign last_idx = (head_job.nbytes == NB_NONE) ? 2'd0 : head_job.nbytes - 2'd1;
    assign is_last  = (idx_reg == last_idx);
    assign pop      = m_valid && m_ready && is_last;

    always_comb begin
        case (idx_reg)
            2'd0:    cur_byte = head_job.bytes[0];
            2'd1:    cur_byte = head_job.bytes[1];
            2'd2:    cur_byte = head_job.bytes[2];
            default: cur_byte = 8'h00;
        endcase

        if (head_job.nbytes == NB_NONE) begin
            // Bare end marker: nothing was left to decode.
            m_data.byte_out      = 8'h00;
            m_data.has_byte      = 1'b0;
            m_data.end_of_output = 1'b1;
        end else begin
            m_data.byte_out      = cur_byte;
            m_data.has_byte      = 1'b1;
            m_data.end_of_output = head_job.end_mark && is_last;
        end

        idx_next = idx_reg;
        if (m_valid && m_ready) begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

// File: hw/rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder.
//
// The s_ channel takes one character per request, with string_end set on the
// final character of an encoded string. The m_ channel returns decoded bytes,
// one per request; end_of_output marks the last result of a string, and a
// result with has_byte low is a bare end marker for a string that decoded to
// nothing more.
//
// A character is taken whenever the job queue has room; the job it causes
// is registered in the queue before its first result appears on m_. The back
// end hands out one result per cycle while m_ready is high, so a full group of
// four characters yields three results, and the character rate is held at one
// per cycle as long as the receiver takes results at least that fast on average.
//
// Reset clears the sextet accumulator, the stop flag and the queue. When the
// receiver stalls, up to QUEUE_DEPTH pending jobs (each up to three bytes)
// are held, after which s_ready drops until the receiver takes results.
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64d_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64d_pkg::out_item_t m_data
);
    import b64d_pkg::*;

    logic      push, pop;
    job_t      push_job, head_job;
    q_status_t q_status;

    b64d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (push_job),
        .rd_en   (pop),
        .rd_data (head_job),
        .status  (q_status)
    );

    b64d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// File: hw/rtl/b64d_checker.sv
// Port-level assertions for the base64 stream decoder, bound to the top level.
module b64d_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input b64d_pkg::out_item_t m_data
);
    import b64d_pkg::*;

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // A result without data only ever closes a string.
    a_bare_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_byte |-> m_data.end_of_output)
        else $error("bare result without end mark");

    a_bare_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_byte |-> m_data.byte_out == 8'h00)
        else $error("bare result carries a nonzero byte");

    // Reset empties the queue, so nothing is offered right after it.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
